// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions on the rising edge of clk, disabled
// while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Invariant checked at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

`endif

// ===== hw/rtl/lesq_pkg.sv =====
// ----------------------------------------------------------------------------
// lesq_pkg
// Types and constants shared by the largest empty square scan unit.
// ----------------------------------------------------------------------------
package lesq_pkg;

	localparam int CFG_DATA_W = 11;
	localparam int CFG_IDX_W  = 1;
	localparam int CHAR_W     = 8;

	localparam int DEF_MAX_WIDTH = 1024;
	localparam int DEF_MAX_ROWS  = 4096;

	// Entries in the queue between front and back.
	localparam int QUEUE_DEPTH = 4;

	localparam logic [CFG_DATA_W-1:0] ROW_LENGTH_RESET = 11'd1024;
	localparam logic [CHAR_W-1:0]     OBSTACLE_RESET   = 8'd111;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_LENGTH    = 1'b0,
		REG_OBSTACLE_CHAR = 1'b1
	} cfg_reg_t;

	// Classification of one cell, decided by the front.
	typedef struct packed {
		logic first;
		logic obst;
	} cls_t;

	localparam int CLS_W = $bits(cls_t);

endpackage

// ===== hw/rtl/lesq_front.sv =====
// ----------------------------------------------------------------------------
// lesq_front
// Accepts cells, keeps the configuration registers and the raster position,
// and classifies each cell before it is queued for the back.
// ----------------------------------------------------------------------------
module lesq_front #(
	parameter int MAX_WIDTH = lesq_pkg::DEF_MAX_WIDTH,
	parameter int MAX_ROWS  = lesq_pkg::DEF_MAX_ROWS,
	parameter int CW        = 10,
	parameter int RW        = 12,
	parameter int SW        = 11
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [lesq_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lesq_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [lesq_pkg::CHAR_W-1:0]      cell_char,
	input  logic                             first_cell,
	input  logic                             q_full,
	output logic                             q_push,
	output logic [CW-1:0]                    push_col,
	output logic [RW-1:0]                    push_row,
	output lesq_pkg::cls_t                   push_cls
);

	localparam int LENW = (lesq_pkg::CFG_DATA_W > SW) ? lesq_pkg::CFG_DATA_W : SW;

	logic [lesq_pkg::CFG_DATA_W-1:0] row_length_q;
	logic [lesq_pkg::CHAR_W-1:0]     obstacle_q;
	logic [CW-1:0]                   col_q, col_d, cur_col;
	logic [RW-1:0]                   row_q, row_d, cur_row;
	logic [LENW-1:0]                 rl_ext, len_c;

	function automatic logic [RW-1:0] row_step(input logic [RW-1:0] r);
		return (r < RW'(MAX_ROWS - 1)) ? r + RW'(1) : r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= lesq_pkg::ROW_LENGTH_RESET;
			obstacle_q   <= lesq_pkg::OBSTACLE_RESET;
		end else if (cfg_wr_en) begin
			unique case (lesq_pkg::cfg_reg_t'(cfg_index))
				lesq_pkg::REG_ROW_LENGTH:    row_length_q <= cfg_data;
				lesq_pkg::REG_OBSTACLE_CHAR: obstacle_q   <= cfg_data[lesq_pkg::CHAR_W-1:0];
				default: ;
			endcase
		end
	end

	// Row length in effect is clamped to 1 .. MAX_WIDTH.
	always_comb begin
		rl_ext = LENW'(row_length_q);
		if (rl_ext == '0)
			len_c = LENW'(1);
		else if (rl_ext > LENW'(MAX_WIDTH))
			len_c = LENW'(MAX_WIDTH);
		else
			len_c = rl_ext;
	end

	always_comb begin
		if (first_cell) begin
			cur_col = '0;
			cur_row = '0;
		end else if (LENW'(col_q) >= len_c) begin
			// The row length shrank mid-row: this cell opens the next row.
			cur_col = '0;
			cur_row = row_step(row_q);
		end else begin
			cur_col = col_q;
			cur_row = row_q;
		end

		if (LENW'(cur_col) + LENW'(1) >= len_c) begin
			col_d = '0;
			row_d = row_step(cur_row);
		end else begin
			col_d = cur_col + CW'(1);
			row_d = cur_row;
		end
	end

	assign in_stall       = q_full;
	assign q_push         = in_valid && !q_full;
	assign push_col       = cur_col;
	assign push_row       = cur_row;
	assign push_cls.first = first_cell;
	assign push_cls.obst  = (cell_char == obstacle_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (q_push) begin
			col_q <= col_d;
			row_q <= row_d;
		end
	end

endmodule

// ===== hw/rtl/lesq_queue.sv =====
// ----------------------------------------------------------------------------
// lesq_queue
// Small first-in first-out queue of classified cells between front and back.
// ----------------------------------------------------------------------------
module lesq_queue #(
	parameter int DATA_W = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              full,
	input  logic              pop,
	output logic [DATA_W-1:0] pop_data,
	output logic              not_empty
);

	localparam int AW = $clog2(lesq_pkg::QUEUE_DEPTH);

	logic [DATA_W-1:0] slot_q [lesq_pkg::QUEUE_DEPTH];
	logic [AW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [AW:0]       count_q;

	assign full      = (count_q == (AW+1)'(lesq_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + AW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + AW'(1);
			if (push && !pop)
				count_q <= count_q + (AW+1)'(1);
			else if (pop && !push)
				count_q <= count_q - (AW+1)'(1);
		end
	end

endmodule

// ===== hw/rtl/lesq_back.sv =====
// ----------------------------------------------------------------------------
// lesq_back
// Reads the line store, scores each cell, tracks the best square and holds
// the result in the output register.
// ----------------------------------------------------------------------------
module lesq_back #(
	parameter int MAX_WIDTH = lesq_pkg::DEF_MAX_WIDTH,
	parameter int CW        = 10,
	parameter int RW        = 12,
	parameter int SW        = 11
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_not_empty,
	input  logic [CW-1:0]  q_col,
	input  logic [RW-1:0]  q_row,
	input  lesq_pkg::cls_t q_cls,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [SW-1:0]  cell_score,
	output logic [SW-1:0]  best_size,
	output logic [RW-1:0]  best_row,
	output logic [CW-1:0]  best_col
);

	logic [SW-1:0] mem [MAX_WIDTH];

	logic           b1_v_q, out_valid_q, fire;
	logic [CW-1:0]  col_s1;
	logic [RW-1:0]  row_s1;
	lesq_pkg::cls_t cls_s1;
	logic           byp_s1, unw_s1;
	logic [SW-1:0]  byp_val_s1, rd_s1;

	// Columns below hwm_q have been written since reset; writes always
	// fill the line store from column zero upward.
	logic [SW-1:0]  hwm_q;
	logic [SW-1:0]  left_q, diag_q, best_size_q;
	logic [RW-1:0]  best_row_q;
	logic [CW-1:0]  best_col_q;

	logic [SW-1:0]  up_mem, up_c, diag_c, left_c, min_c, score_c, best_cur;
	logic [SW-1:0]  best_size_n;
	logic [RW-1:0]  best_row_n;
	logic [CW-1:0]  best_col_n;
	logic           col0, row0;

	assign fire  = b1_v_q && (!out_valid_q || !out_stall);
	assign q_pop = q_not_empty && (!b1_v_q || fire);

	always_comb begin
		up_mem = byp_s1 ? byp_val_s1 : (unw_s1 ? '0 : rd_s1);
		col0   = (col_s1 == '0);
		row0   = (row_s1 == '0);
		up_c   = row0 ? '0 : up_mem;
		diag_c = (row0 || col0) ? '0 : diag_q;
		left_c = col0 ? '0 : left_q;
		min_c  = (up_c < diag_c) ? up_c : diag_c;
		min_c  = (min_c < left_c) ? min_c : left_c;
		if (cls_s1.obst)
			score_c = '0;
		else if (col0)
			score_c = SW'(1);
		else
			score_c = min_c + SW'(1);

		best_cur = cls_s1.first ? '0 : best_size_q;
		if (score_c > best_cur) begin
			best_size_n = score_c;
			best_row_n  = row_s1;
			best_col_n  = col_s1;
		end else begin
			best_size_n = best_cur;
			best_row_n  = cls_s1.first ? '0 : best_row_q;
			best_col_n  = cls_s1.first ? '0 : best_col_q;
		end
	end

	// Line store: one write from the scoring stage, one registered read as a
	// cell enters it.
	always_ff @(posedge clk) begin
		if (fire)
			mem[col_s1] <= score_c;
		if (q_pop)
			rd_s1 <= mem[q_col];
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			col_s1     <= q_col;
			row_s1     <= q_row;
			cls_s1     <= q_cls;
			// A write to the same column in this cycle is forwarded.
			byp_s1     <= fire && (col_s1 == q_col);
			byp_val_s1 <= score_c;
			unw_s1     <= (SW'(q_col) >= hwm_q);
		end
		if (fire) begin
			cell_score <= score_c;
			best_size  <= best_size_n;
			best_row   <= best_row_n;
			best_col   <= best_col_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b1_v_q      <= 1'b0;
			out_valid_q <= 1'b0;
			hwm_q       <= '0;
			left_q      <= '0;
			diag_q      <= '0;
			best_size_q <= '0;
			best_row_q  <= '0;
			best_col_q  <= '0;
		end else begin
			if (q_pop)
				b1_v_q <= 1'b1;
			else if (fire)
				b1_v_q <= 1'b0;

			if (fire)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			if (fire) begin
				if (SW'(col_s1) == hwm_q)
					hwm_q <= hwm_q + SW'(1);
				left_q      <= score_c;
				diag_q      <= up_c;
				best_size_q <= best_size_n;
				best_row_q  <= best_row_n;
				best_col_q  <= best_col_n;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hw/rtl/largest_empty_square_scan_unit.sv =====
// ----------------------------------------------------------------------------
// largest_empty_square_scan_unit
// Raster scan for the largest all-empty square in a character map.
//
//   channel | direction | transaction
//   --------+-----------+-------------------------------------------------
//   in      | input     | cell_char, first_cell (one map cell, row-major)
//   out     | output    | cell_score, best_size, best_row, best_col
//   cfg     | input     | cfg_index, cfg_data (write only, no handshake)
//
// One cell is accepted per clock cycle and one result transaction leaves per
// cycle while out_stall is low; the scoring stage, with its registered
// line-store read, sets that rate. A cell passes through the queue and the
// scoring-stage registers; its result is presented from the output register.
// Reset is asynchronous and needs no clearing pass: a fill mark tracks which
// line-store columns hold data, and any other column reads as zero.
// A stall on the output holds the result register; the queue between front
// and back absorbs up to four cells before in_stall rises.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module largest_empty_square_scan_unit #(
	parameter int MAX_WIDTH = lesq_pkg::DEF_MAX_WIDTH,
	parameter int MAX_ROWS  = lesq_pkg::DEF_MAX_ROWS,
	// Widths of the column, row and score fields follow from the limits.
	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
	localparam int SW = $clog2(MAX_WIDTH + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration writes
	input  logic                            cfg_wr_en,
	input  logic [lesq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lesq_pkg::CFG_DATA_W-1:0] cfg_data,
	// Input cells
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [lesq_pkg::CHAR_W-1:0]     cell_char,
	input  logic                            first_cell,
	// Results
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [SW-1:0]                   cell_score,
	output logic [SW-1:0]                   best_size,
	output logic [RW-1:0]                   best_row,
	output logic [CW-1:0]                   best_col
);

	// Queue entry layout: classification, row, column.
	localparam int QW = lesq_pkg::CLS_W + RW + CW;

	logic           q_push, q_full, q_pop, q_not_empty;
	logic [CW-1:0]  push_col;
	logic [RW-1:0]  push_row;
	lesq_pkg::cls_t push_cls;
	logic [QW-1:0]  push_data, pop_data;

	// The front tracks the raster position and classifies each cell as it
	// is accepted, so the back only has to score it.
	lesq_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_ROWS  (MAX_ROWS),
		.CW        (CW),
		.RW        (RW),
		.SW        (SW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cell_char  (cell_char),
		.first_cell (first_cell),
		.q_full     (q_full),
		.q_push     (q_push),
		.push_col   (push_col),
		.push_row   (push_row),
		.push_cls   (push_cls)
	);

	assign push_data = {push_cls, push_row, push_col};

	lesq_queue #(
		.DATA_W (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (pop_data),
		.not_empty (q_not_empty)
	);

	// The back reads the previous-row score for the popped column, then
	// scores the cell against its up, up-left and left neighbors and keeps
	// the first strictly largest square.
	lesq_back #(
		.MAX_WIDTH (MAX_WIDTH),
		.CW        (CW),
		.RW        (RW),
		.SW        (SW)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_col       (pop_data[CW-1:0]),
		.q_row       (pop_data[CW +: RW]),
		.q_cls       (lesq_pkg::cls_t'(pop_data[QW-1 -: lesq_pkg::CLS_W])),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.cell_score  (cell_score),
		.best_size   (best_size),
		.best_row    (best_row),
		.best_col    (best_col)
	);

	// With no square found yet, the reported corner is the origin.
	`ASSERT_IMPLY(a_no_best_at_origin, out_valid && (best_size == '0),
		(best_row == '0) && (best_col == '0), "best position set while best size is zero")

	// The best size covers the score of the cell just reported.
	`ASSERT_IMPLY(a_best_covers_score, out_valid, cell_score <= best_size,
		"cell score exceeds best size")

	// The input can only back up while a result is held in the output register.
	`ASSERT_IMPLY(a_stall_needs_result, in_stall, out_valid,
		"input stalled without a held result")

endmodule
